>>> rtl/core/swp_pkg.sv
// package with item types, command and status structs and constants for the plotter
`default_nettype none

package swp_pkg;

    // input item: one pixel of the incoming frame
    typedef struct packed {
        logic [23:0] pixel;
        logic        frame_start;
    } src_item_t;

    // result item: one point request
    typedef struct packed {
        logic        plot;
        logic [10:0] plot_col;
        logic [10:0] plot_row;
    } dst_item_t;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_SPACING = 2'd2;
    localparam logic [1:0] CFG_GAIN_DIVISOR = 2'd3;

    localparam int CFG_DATA_W = 12;

    // reset values of the configuration registers
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd640;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [6:0]  RST_LINE_SPACING = 7'd6;
    localparam logic [7:0]  RST_GAIN_DIVISOR = 8'd50;

    // brightness 2R+4G+B is 11 bits wide, one quotient bit per divider step
    localparam int BRIGHT_W  = 11;
    localparam int DIV_STEPS = BRIGHT_W;
    localparam int STEP_W    = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    localparam int OUT_W = 11;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

>>> rtl/core/swp_ctrl.sv
// controller state machine: accept, divide, emit
`default_nettype none

module swp_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              src_valid,
    output logic                   src_ready,
    input  wire swp_pkg::dp_status_t status,
    output swp_pkg::ctl_cmd_t      cmd
);

    swp_pkg::ctl_state_t state_reg;
    swp_pkg::ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            swp_pkg::ST_IDLE:
            begin
                if (src_valid)
                begin
                    state_next = swp_pkg::ST_DIVIDE;
                end
            end
            swp_pkg::ST_DIVIDE:
            begin
                if (status.div_last)
                begin
                    state_next = swp_pkg::ST_EMIT;
                end
            end
            swp_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = swp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        src_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            swp_pkg::ST_IDLE:
            begin
                src_ready = 1'b1;
                cmd.load  = src_valid;
            end
            swp_pkg::ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            swp_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                src_ready = 1'b0;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_load_to_divide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == swp_pkg::ST_DIVIDE)
        else $error("accepted item did not start the divider");

    a_divide_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == swp_pkg::ST_DIVIDE && !status.div_last)
            |=> state_reg == swp_pkg::ST_DIVIDE)
        else $error("divider left before its last step");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free && !src_ready)
        else $error("result emitted into a full output register");
`endif

endmodule

`default_nettype wire

>>> rtl/core/swp_dpath.sv
// datapath: config registers, raster counters, bit-serial divider, output register
`default_nettype none

module swp_dpath #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [swp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire swp_pkg::src_item_t             src_data,
    input  wire swp_pkg::ctl_cmd_t              cmd,
    output swp_pkg::dp_status_t                 status,
    output logic                                dst_valid,
    input  wire logic                           dst_ready,
    output swp_pkg::dst_item_t                  dst_data
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int CNT_W  = (CW > RW) ? CW : RW;
    localparam int WIDE   = ((CNT_W > swp_pkg::CFG_DATA_W) ? CNT_W : swp_pkg::CFG_DATA_W) + 1;
    localparam int BW     = swp_pkg::BRIGHT_W;

    // configuration registers
    logic [11:0] frame_width_reg;
    logic [11:0] frame_height_reg;
    logic [6:0]  line_spacing_reg;
    logic [7:0]  gain_divisor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= swp_pkg::RST_FRAME_WIDTH;
            frame_height_reg <= swp_pkg::RST_FRAME_HEIGHT;
            line_spacing_reg <= swp_pkg::RST_LINE_SPACING;
            gain_divisor_reg <= swp_pkg::RST_GAIN_DIVISOR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swp_pkg::CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[11:0];
                swp_pkg::CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[11:0];
                swp_pkg::CFG_LINE_SPACING: line_spacing_reg <= cfg_data[6:0];
                swp_pkg::CFG_GAIN_DIVISOR: gain_divisor_reg <= cfg_data[7:0];
                default:                   frame_width_reg  <= frame_width_reg;
            endcase
        end
    end

    // effective sizes: zero reads as one, clamp to the maximum
    logic [WIDE-1:0] eff_width;
    logic [WIDE-1:0] eff_height;
    logic [7:0]      eff_spacing;
    logic [7:0]      eff_divisor;

    always_comb
    begin
        if (frame_width_reg == '0)
            eff_width = WIDE'(1);
        else if (WIDE'(frame_width_reg) > WIDE'(MAX_WIDTH))
            eff_width = WIDE'(MAX_WIDTH);
        else
            eff_width = WIDE'(frame_width_reg);

        if (frame_height_reg == '0)
            eff_height = WIDE'(1);
        else if (WIDE'(frame_height_reg) > WIDE'(MAX_HEIGHT))
            eff_height = WIDE'(MAX_HEIGHT);
        else
            eff_height = WIDE'(frame_height_reg);

        eff_spacing = (line_spacing_reg == '0) ? 8'd1 : {1'b0, line_spacing_reg};
        eff_divisor = (gain_divisor_reg == '0) ? 8'd1 : gain_divisor_reg;
    end

    // raster counters
    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_reg;
    logic [RW-1:0] row_next;
    logic [6:0]    phase_reg;
    logic [6:0]    phase_next;

    // position of the pixel being judged, after a frame start clears it
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [6:0]    cur_phase;

    always_comb
    begin
        cur_col   = src_data.frame_start ? '0 : col_reg;
        cur_row   = src_data.frame_start ? '0 : row_reg;
        cur_phase = src_data.frame_start ? '0 : phase_reg;

        col_next   = cur_col;
        row_next   = cur_row;
        phase_next = cur_phase;
        if (WIDE'(cur_col) + WIDE'(1) >= eff_width)
        begin
            col_next = '0;
            if (WIDE'(cur_row) + WIDE'(1) >= eff_height)
            begin
                row_next   = '0;
                phase_next = '0;
            end
            else
            begin
                row_next   = cur_row + RW'(1);
                phase_next = ({1'b0, cur_phase} + 8'd1 >= eff_spacing)
                           ? '0 : cur_phase + 7'd1;
            end
        end
        else
        begin
            col_next = cur_col + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            phase_reg <= '0;
        end
        else if (cmd.load)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            phase_reg <= phase_next;
        end
    end

    // held position of the item in flight
    logic [CW-1:0] hold_col_reg;
    logic [RW-1:0] hold_row_reg;
    logic          hold_draw_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            hold_col_reg  <= cur_col;
            hold_row_reg  <= cur_row;
            hold_draw_reg <= (cur_phase == '0);
        end
    end

    // brightness 2R + 4G + B
    logic [BW-1:0] bright;

    always_comb
    begin
        bright = BW'({src_data.pixel[23:16], 1'b0})
               + BW'({src_data.pixel[15:8], 2'b00})
               + BW'(src_data.pixel[7:0]);
    end

    // restoring divider, one quotient bit per step
    logic [BW-1:0]             quo_reg;
    logic [7:0]                rem_reg;
    logic [swp_pkg::STEP_W-1:0] step_reg;
    logic [8:0]                rem_shift;
    logic                      rem_ge;
    logic [8:0]                rem_diff;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[BW-1]};
        rem_ge    = rem_shift >= {1'b0, eff_divisor};
        rem_diff  = rem_shift - {1'b0, eff_divisor};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg  <= bright;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.step)
        begin
            quo_reg  <= {quo_reg[BW-2:0], rem_ge};
            rem_reg  <= rem_ge ? rem_diff[7:0] : rem_shift[7:0];
            step_reg <= step_reg + swp_pkg::STEP_W'(1);
        end
    end

    // plot decision on the finished quotient
    logic [WIDE-1:0] row_wide;
    logic [WIDE-1:0] col_wide;
    logic [WIDE-1:0] row_diff;
    logic            do_plot;

    always_comb
    begin
        row_wide = WIDE'(hold_row_reg);
        col_wide = WIDE'(hold_col_reg);
        row_diff = row_wide - WIDE'(quo_reg);
        do_plot  = hold_draw_reg && (row_wide > WIDE'(quo_reg));
    end

    // output register
    logic               dst_valid_reg;
    swp_pkg::dst_item_t dst_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            dst_valid_reg <= 1'b1;
        end
        else if (dst_ready)
        begin
            dst_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            dst_data_reg.plot     <= do_plot;
            dst_data_reg.plot_col <= do_plot ? col_wide[swp_pkg::OUT_W-1:0] : '0;
            dst_data_reg.plot_row <= do_plot ? row_diff[swp_pkg::OUT_W-1:0] : '0;
        end
    end

    assign dst_valid = dst_valid_reg;
    assign dst_data  = dst_data_reg;

    // status: div_last, then out_free
    assign status = {step_reg == swp_pkg::LAST_STEP, !dst_valid_reg || dst_ready};

`ifndef ASSERT_OFF
    a_load_clears_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> step_reg == '0)
        else $error("divider step count not cleared on load");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> dst_valid_reg)
        else $error("emitted result not presented");

    a_no_plot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid_reg && !dst_data_reg.plot)
            |-> (dst_data_reg.plot_col == '0 && dst_data_reg.plot_row == '0))
        else $error("non-plot result carries a position");
`endif

endmodule

`default_nettype wire

>>> rtl/core/scanline_waveform_plotter.sv
// top level: scanline waveform plotter, controller plus datapath
// an accepted item is loaded, divided in the 11-step bit-serial divider, then emitted into the output register;
//   emitting waits while the output register still holds a stalled result
// a new item is accepted only after the previous one has been emitted
// a result can wait in the output register while the next item is accepted
// reset: rst_n asynchronous active low clears raster counters, control, output valid and config to defaults
`default_nettype none

module scanline_waveform_plotter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [1:0]                     cfg_index,
    input  wire logic [swp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           src_valid,
    output logic                                src_ready,
    input  wire swp_pkg::src_item_t             src_data,
    output logic                                dst_valid,
    input  wire logic                           dst_ready,
    output swp_pkg::dst_item_t                  dst_data
);

    swp_pkg::ctl_cmd_t   cmd;
    swp_pkg::dp_status_t status;

    // sequencing
    swp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // counters, divider and output register
    swp_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_data  (src_data),
        .cmd       (cmd),
        .status    (status),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

endmodule

`default_nettype wire

>>> sim/swp_point_checker.sv
// checker for the plotter: predicts each point request and compares it with the block's output
module swp_point_checker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [swp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           src_valid,
    input  logic                           src_ready,
    input  swp_pkg::src_item_t             src_data,
    input  logic                           dst_valid,
    input  logic                           dst_ready,
    input  swp_pkg::dst_item_t             dst_data,
    output int                             errors,
    output int                             outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import swp_pkg::*;

    // shadow copy of the registers
    logic [11:0] width_reg;
    logic [11:0] height_reg;
    logic [6:0]  spacing_reg;
    logic [7:0]  gain_reg;

    // raster position of the next pixel
    logic [10:0] col_pos;
    logic [10:0] row_pos;
    logic [6:0]  phase_pos;

    dst_item_t point_q[$];
    dst_item_t want;
    int        fail_cnt;

    // judge one pixel and step the raster counters
    function automatic dst_item_t next_point(input src_item_t px);
        dst_item_t res;
        int w;
        int h;
        int sp;
        int dv;
        int bright;
        int quot;
        w  = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h  = (height_reg == 0) ? 1 :
             ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
        sp = (spacing_reg == 0) ? 1 : int'(spacing_reg);
        dv = (gain_reg == 0) ? 1 : int'(gain_reg);
        res = '0;

        // frame start clears the counters before the pixel is judged
        if (px.frame_start)
        begin
            col_pos   = '0;
            row_pos   = '0;
            phase_pos = '0;
        end

        // only rows on the line spacing can plot
        if (phase_pos == 0)
        begin
            bright = 2 * int'(px.pixel[23:16]) + 4 * int'(px.pixel[15:8])
                   + int'(px.pixel[7:0]);
            quot   = bright / dv;
            if (int'(row_pos) > quot)
            begin
                res.plot     = 1'b1;
                res.plot_col = col_pos;
                res.plot_row = 11'(int'(row_pos) - quot);
            end
        end

        // raster advance, a counter past a shrunken size wraps at once
        if (int'(col_pos) + 1 >= w)
        begin
            col_pos = '0;
            if (int'(row_pos) + 1 >= h)
            begin
                row_pos   = '0;
                phase_pos = '0;
            end
            else
            begin
                row_pos   = row_pos + 11'd1;
                phase_pos = (int'(phase_pos) + 1 >= sp) ? 7'd0 : phase_pos + 7'd1;
            end
        end
        else
        begin
            col_pos = col_pos + 11'd1;
        end
        return res;
    endfunction

    // watch config, input and output channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   = RST_FRAME_WIDTH;
            height_reg  = RST_FRAME_HEIGHT;
            spacing_reg = RST_LINE_SPACING;
            gain_reg    = RST_GAIN_DIVISOR;
            col_pos     = '0;
            row_pos     = '0;
            phase_pos   = '0;
            point_q.delete();
            fail_cnt    = 0;
            errors      <= 0;
            outstanding <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FRAME_WIDTH:  width_reg   = cfg_data[11:0];
                    CFG_FRAME_HEIGHT: height_reg  = cfg_data[11:0];
                    CFG_LINE_SPACING: spacing_reg = cfg_data[6:0];
                    CFG_GAIN_DIVISOR: gain_reg    = cfg_data[7:0];
                    default: ;
                endcase
            end

            // compare a delivered point with the oldest prediction
            if (dst_valid && dst_ready)
            begin
                if (point_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("unexpected point: plot=%0d col=%0d row=%0d",
                                 dst_data.plot, dst_data.plot_col, dst_data.plot_row);
                end
                else
                begin
                    want = point_q.pop_front();
                    if (dst_data.plot !== want.plot || dst_data.plot_col !== want.plot_col ||
                        dst_data.plot_row !== want.plot_row)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("point mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.plot, want.plot_col, want.plot_row,
                                     dst_data.plot, dst_data.plot_col, dst_data.plot_row);
                    end
                end
            end

            // predict the point for an accepted pixel
            if (src_valid && src_ready)
                point_q.push_back(next_point(src_data));

            errors      <= fail_cnt;
            outstanding <= point_q.size();
        end
    end

endmodule

>>> sim/scanline_waveform_plotter_tb.sv
// testbench top for the plotter: pixel stimulus, output stalls and the verdict
module scanline_waveform_plotter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import swp_pkg::*;

    localparam int MAX_W       = 2048;
    localparam int MAX_H       = 2048;
    localparam int RAND_PHASES = 9;
    localparam int HOLD_PHASE  = 3;
    localparam int HOLD_LEN    = 300;
    localparam int CYCLE_LIMIT = 200000;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [1:0]            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  src_valid;
    logic                  src_ready;
    src_item_t             src_data;
    logic                  dst_valid;
    logic                  dst_ready;
    dst_item_t             dst_data;

    int   errors;
    int   outstanding;
    int   cycle_cnt;
    int   stall_left;
    int   hold_cycles;
    logic hold_req;
    logic quiet;

    scanline_waveform_plotter #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .dst_valid (dst_valid),
        .dst_ready (dst_ready),
        .dst_data  (dst_data)
    );

    swp_point_checker #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .src_valid   (src_valid),
        .src_ready   (src_ready),
        .src_data    (src_data),
        .dst_valid   (dst_valid),
        .dst_ready   (dst_ready),
        .dst_data    (dst_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output side: one long hold-off on request, else random stall bursts
    always @(posedge clk)
    begin
        if (hold_req && hold_cycles < HOLD_LEN)
        begin
            dst_ready   <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else if (stall_left != 0)
        begin
            dst_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            dst_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 6);
        end
        else
        begin
            dst_ready <= 1'b1;
        end
    end

    // random pixel: full range, dark ones that tend to plot, and pure colors
    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(0, 3))
            0: return 24'($urandom);
            1: return 24'($urandom) & 24'h0f0f0f;
            2: return 24'($urandom) & 24'h030103;
            default:
                case ($urandom_range(0, 2))
                    0: return 24'h000000;
                    1: return 24'hffffff;
                    default: return 24'hff << (8 * $urandom_range(0, 2));
                endcase
        endcase
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [11:0] w, input logic [11:0] h,
                            input logic [11:0] sp, input logic [11:0] g);
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_LINE_SPACING, sp);
        write_reg(CFG_GAIN_DIVISOR, g);
        cfg_we <= 1'b0;
    endtask

    // offer one pixel, with an optional gap first, and wait for acceptance
    task automatic offer_pixel(input logic [23:0] pix, input logic start);
        src_item_t it;
        it.pixel       = pix;
        it.frame_start = start;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_data  <= it;
        do @(posedge clk); while (!src_ready);
    endtask

    // stop offering and wait until every predicted point has come out
    task automatic drain();
        src_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    initial
    begin
        int          n;
        logic        fresh;
        logic [11:0] w;
        logic [11:0] h;
        logic [11:0] sp;
        logic [11:0] g;

        cycle_cnt   <= 0;
        stall_left  <= 0;
        hold_cycles <= 0;
        hold_req    <= 1'b0;
        quiet       <= 1'b0;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_FRAME_WIDTH;
        cfg_data    <= '0;
        src_valid   <= 1'b0;
        src_data    <= '0;
        dst_ready   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, extreme pixels
        offer_pixel(24'h000000, 1'b1);
        offer_pixel(24'hffffff, 1'b0);
        offer_pixel(24'hff0000, 1'b0);
        offer_pixel(24'h00ff00, 1'b0);
        offer_pixel(24'h0000ff, 1'b0);
        drain();

        // zero width, spacing and divisor fall back to one; oversize height clamps
        set_regs(12'd0, 12'hfff, 12'd0, 12'd0);
        offer_pixel(24'h000000, 1'b1);
        offer_pixel(24'h000000, 1'b0);
        offer_pixel(24'h000001, 1'b0);
        offer_pixel(24'hffffff, 1'b0);
        offer_pixel(24'h7f7f7f, 1'b0);
        offer_pixel(24'h000000, 1'b0);
        drain();

        // shrink the frame under the running counters, frame start mid-stream
        set_regs(12'd2, 12'd3, 12'd2, 12'd1);
        for (int i = 0; i < 8; i++)
            offer_pixel(24'h000000, i == 5);
        drain();

        // oversize width, single line, large spacing and divisor
        set_regs(12'hfff, 12'd1, 12'd100, 12'd200);
        offer_pixel(24'hffffff, 1'b1);
        offer_pixel(24'h000000, 1'b0);
        offer_pixel(24'h123456, 1'b0);
        drain();

        // random phases, mostly small frames so rows advance and points appear
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            quiet <= (ph == RAND_PHASES - 1);
            case ($urandom_range(0, 9))
                0: w = 12'd0;
                1: w = 12'd1;
                2: w = 12'hfff;
                default: w = 12'($urandom_range(2, 6));
            endcase
            case ($urandom_range(0, 9))
                0: h = 12'd0;
                1: h = 12'd1;
                2: h = 12'hfff;
                default: h = 12'($urandom_range(2, 40));
            endcase
            case ($urandom_range(0, 9))
                0: sp = 12'd0;
                1: sp = 12'd1;
                2: sp = 12'd100;
                3: sp = 12'd127;
                default: sp = 12'($urandom_range(2, 5));
            endcase
            case ($urandom_range(0, 9))
                0: g = 12'd0;
                1: g = 12'd1;
                2: g = 12'd200;
                3: g = 12'd255;
                default: g = 12'($urandom_range(2, 254));
            endcase
            set_regs(w, h, sp, g);

            // output side holds off while pixels keep coming
            if (ph == HOLD_PHASE)
                hold_req <= 1'b1;

            fresh = ($urandom_range(0, 1) == 1);
            n     = $urandom_range(35, 60);
            for (int i = 0; i < n; i++)
                offer_pixel(rand_pixel(), (i == 0 && fresh) || $urandom_range(0, 59) == 0);
            drain();
        end

        // let any stray output show up before the verdict
        repeat (30) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
